FILE: rtl/kp400_pkg.sv
// Shared types, constants and functions for the Keccak-p[400] round.
`default_nettype none
package kp400_pkg;

  localparam int LANE_W     = 16;
  localparam int GRID       = 5;
  localparam int NUM_LANES  = GRID * GRID;
  localparam int STATE_W    = NUM_LANES * LANE_W;
  localparam int ROT_W      = $clog2(LANE_W);
  localparam int ROUND_W    = 5;
  localparam int NUM_ROUNDS = 20;

  typedef logic [LANE_W-1:0]                 lane_t;
  typedef logic [GRID-1:0][LANE_W-1:0]       row_t;
  typedef logic [NUM_LANES-1:0][LANE_W-1:0]  state_t;
  typedef logic [ROT_W-1:0]                  rot_t;
  typedef logic [ROUND_W-1:0]                round_t;

  // Left rotation of one lane.
  function automatic lane_t rotl(input lane_t v, input rot_t r);
    logic [2*LANE_W-1:0] dbl;
    dbl = {v, v} << r;
    return dbl[2*LANE_W-1:LANE_W];
  endfunction

  // Rho offsets, already reduced modulo the lane width.
  function automatic rot_t rho_offset(input int idx);
    rot_t r;
    unique case (idx)
      0:  r = rot_t'(0);
      1:  r = rot_t'(1);
      2:  r = rot_t'(14);
      3:  r = rot_t'(12);
      4:  r = rot_t'(11);
      5:  r = rot_t'(4);
      6:  r = rot_t'(12);
      7:  r = rot_t'(6);
      8:  r = rot_t'(7);
      9:  r = rot_t'(4);
      10: r = rot_t'(3);
      11: r = rot_t'(10);
      12: r = rot_t'(11);
      13: r = rot_t'(9);
      14: r = rot_t'(7);
      15: r = rot_t'(9);
      16: r = rot_t'(13);
      17: r = rot_t'(15);
      18: r = rot_t'(5);
      19: r = rot_t'(8);
      20: r = rot_t'(2);
      21: r = rot_t'(2);
      22: r = rot_t'(13);
      23: r = rot_t'(8);
      24: r = rot_t'(14);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Iota round constants; indices past the last round give zero.
  function automatic lane_t round_const(input round_t rnd);
    lane_t rc;
    unique case (rnd)
      5'd0:  rc = 16'h0001;
      5'd1:  rc = 16'h8082;
      5'd2:  rc = 16'h808A;
      5'd3:  rc = 16'h8000;
      5'd4:  rc = 16'h808B;
      5'd5:  rc = 16'h0001;
      5'd6:  rc = 16'h8081;
      5'd7:  rc = 16'h8009;
      5'd8:  rc = 16'h008A;
      5'd9:  rc = 16'h0088;
      5'd10: rc = 16'h8009;
      5'd11: rc = 16'h000A;
      5'd12: rc = 16'h808B;
      5'd13: rc = 16'h008B;
      5'd14: rc = 16'h8089;
      5'd15: rc = 16'h8003;
      5'd16: rc = 16'h8002;
      5'd17: rc = 16'h0080;
      5'd18: rc = 16'h800A;
      5'd19: rc = 16'h000A;
      default: rc = '0;
    endcase
    return rc;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/kp400_column.sv
// Column parity lane for theta: xor of the five lanes of one column.
`default_nettype none
module kp400_column (
  input  kp400_pkg::row_t  col_lanes,
  output kp400_pkg::lane_t parity
);
  import kp400_pkg::*;

  always_comb begin
    parity = '0;
    for (int y = 0; y < GRID; y++) begin
      parity = parity ^ col_lanes[y];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/kp400_row.sv
// Chi lane: non-linear mixing of the five lanes of one row.
`default_nettype none
module kp400_row (
  input  kp400_pkg::row_t row_in,
  output kp400_pkg::row_t row_out
);
  import kp400_pkg::*;

  always_comb begin
    for (int x = 0; x < GRID; x++) begin
      row_out[x] = row_in[x] ^ (~row_in[(x + 1) % GRID] & row_in[(x + 2) % GRID]);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/keccak_p400_round.sv
// Top level: one Keccak-p[400] round with a registered result stage.
//
//  channel | direction | tdata                         | tuser
//  in_     | slave     | lanes 0..24, 16 bits each     | round_number
//  out_    | master    | new lanes 0..24, 16 bits each | -
//
// Theta, rho, pi, chi and iota are evaluated in a single
// pass between the input port and the output register.
// One transaction per cycle is sustained while out_tready is high; the output register sets that rate.
// A new transaction is taken whenever the output register is empty or is
// being drained in the same cycle. Reset empties the output register.
`default_nettype none
module keccak_p400_round (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // lanes_0_3, lanes_4_7, lanes_8_11, lanes_12_15, lanes_16_19, lanes_20_23, lane_24
  input  wire logic [kp400_pkg::STATE_W-1:0] in_tdata,
  // round_number
  input  wire logic [kp400_pkg::ROUND_W-1:0] in_tuser,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // out_lanes_0_3, out_lanes_4_7, out_lanes_8_11, out_lanes_12_15,
  // out_lanes_16_19, out_lanes_20_23, out_lane_24
  output logic [kp400_pkg::STATE_W-1:0]   out_tdata
);
  import kp400_pkg::*;

  state_t a;
  row_t   c;
  row_t   d;
  state_t b;
  state_t chi_out;
  state_t result;
  logic   valid_r;
  logic   valid_nxt;
  state_t data_r;

  assign a = state_t'(in_tdata);

  genvar gx, gy;
  generate
    for (gx = 0; gx < GRID; gx++) begin : g_col
      row_t col;
      for (gy = 0; gy < GRID; gy++) begin : g_gather
        assign col[gy] = a[gx + GRID * gy];
      end
      kp400_column u_column (
        .col_lanes (col),
        .parity    (c[gx])
      );
    end

    // Merge the column parities into the theta correction for each column.
    for (gx = 0; gx < GRID; gx++) begin : g_merge
      assign d[gx] = c[(gx + GRID - 1) % GRID] ^ rotl(c[(gx + 1) % GRID], rot_t'(1));
    end

    // Theta, rho and pi: every lane takes the theta correction, is rotated and moved to its new place.
    for (gx = 0; gx < GRID; gx++) begin : g_rho_x
      for (gy = 0; gy < GRID; gy++) begin : g_rho_y
        localparam int SRC = gx + GRID * gy;
        localparam int DST = gy + GRID * ((2 * gx + 3 * gy) % GRID);
        assign b[DST] = rotl(a[SRC] ^ d[gx], rho_offset(SRC));
      end
    end

    for (gy = 0; gy < GRID; gy++) begin : g_row
      row_t row_in;
      row_t row_out;
      for (gx = 0; gx < GRID; gx++) begin : g_io
        assign row_in[gx]                = b[gx + GRID * gy];
        assign chi_out[gx + GRID * gy]   = row_out[gx];
      end
      kp400_row u_row (
        .row_in  (row_in),
        .row_out (row_out)
      );
    end
  endgenerate

  always_comb begin
    result    = chi_out;
    result[0] = chi_out[0] ^ round_const(in_tuser);
  end

  assign in_tready = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      data_r <= result;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = STATE_W'(data_r);

endmodule
`default_nettype wire
